>>> hw/rtl/multi_phase_sine_wave_generator_assert.svh
// ----------------------------------------------------------------------------
// multi_phase_sine_wave_generator assertion macros
// clocked on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef MULTI_PHASE_SINE_WAVE_GENERATOR_ASSERT_SVH
`define MULTI_PHASE_SINE_WAVE_GENERATOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define MPSG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define MPSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// expression holds at every clock
`define MPSG_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

`endif

>>> hw/rtl/mpsg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsg_pkg
// shared constants, types and the quarter-wave sine table
// ----------------------------------------------------------------------------
package mpsg_pkg;

  localparam int NUM_MODULES     = 5;
  localparam int SINE_TABLE_BITS = 10;
  localparam int NUM_SLOTS       = 5;

  localparam int TICK_W  = 16;
  localparam int STEP_W  = 32;
  localparam int AMP_W   = 7;
  localparam int LAG_W   = 17;
  localparam int PHASE_W = 32;
  localparam int ANGLE_W = 8;
  localparam int SINE_W  = 15;
  localparam int OUT_W   = NUM_SLOTS * ANGLE_W;

  localparam int QUARTER_BITS = SINE_TABLE_BITS - 2;
  localparam int QUARTER      = 2 ** QUARTER_BITS;

  // lag offset step: lag*2^16/N split into whole part and remainder
  // lag/N by reciprocal multiply, exact for 17 bit lags with N of 5
  localparam int LAG_SHIFT       = 16;
  localparam int LAG_Q_W         = PHASE_W - LAG_SHIFT;
  localparam int LAG_RECIP_SHIFT = 20;
  localparam int LAG_RECIP_W     = LAG_RECIP_SHIFT;
  localparam logic [LAG_RECIP_W-1:0] LAG_RECIP =
    LAG_RECIP_W'((2 ** LAG_RECIP_SHIFT + NUM_MODULES - 1) / NUM_MODULES);
  // sequencer steps before the wave walk: lag split, then accumulate
  localparam int DIV_STEPS  = 2;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int REM_W      = $clog2(NUM_MODULES);
  localparam int WAVE_W     = $clog2(NUM_MODULES);

  // per lag remainder r: low quotient bits of r*2^16/N and the leftover
  typedef logic [LAG_SHIFT-1:0] lag_frac_tab_t [NUM_MODULES];
  typedef logic [REM_W-1:0]     lag_frem_tab_t [NUM_MODULES];

  function automatic lag_frac_tab_t build_lag_frac();
    lag_frac_tab_t t;
    for (int r = 0; r < NUM_MODULES; r++) begin
      t[r] = LAG_SHIFT'((r * (2 ** LAG_SHIFT)) / NUM_MODULES);
    end
    return t;
  endfunction

  function automatic lag_frem_tab_t build_lag_frem();
    lag_frem_tab_t t;
    for (int r = 0; r < NUM_MODULES; r++) begin
      t[r] = REM_W'((r * (2 ** LAG_SHIFT)) % NUM_MODULES);
    end
    return t;
  endfunction

  localparam lag_frac_tab_t LAG_FRAC = build_lag_frac();
  localparam lag_frem_tab_t LAG_FREM = build_lag_frem();

  // config register map
  localparam int REG_IDX_W = 2;
  localparam int PADDR_W   = REG_IDX_W + 2;
  localparam logic [REG_IDX_W-1:0] REG_PHASE_STEP = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_AMPLITUDE  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LAG_SPAN   = 2'd2;

  localparam logic [STEP_W-1:0] PHASE_STEP_RST = 32'd4295;
  localparam logic [AMP_W-1:0]  AMPLITUDE_RST  = 7'd0;
  localparam logic [LAG_W-1:0]  LAG_SPAN_RST   = 17'd65536;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;       // latch ticks, lag quotient, seed wave walk
    logic div_step;   // lag remainder and offset step
    logic mul;        // ticks * phase_step
    logic acc;        // phase accumulator update
    logic idx;        // wave phase -> table index, advance offset
    logic lut;        // table read
    logic slot;       // scale and write slot angle
    logic wave_next;  // move to the next wave
    logic out_load;   // copy slots to the output word
  } dp_cmd_t;

  typedef struct packed {
    logic wave_last;
  } dp_sts_t;

  // quarter-wave table, Q0.15 magnitudes from a truncating Taylor series
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic [63:0] TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                            64'd110, 64'd156, 64'd210};

  typedef logic [SINE_W-1:0] quarter_tab_t [QUARTER];

  function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned q);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] sum;
    x    = (64'(q) * TWO_PI_Q30) >> SINE_TABLE_BITS;
    x2   = (x * x) >> 30;
    term = x;
    pos  = x;
    neg  = 64'd0;
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
      if ((n & 1) != 0) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    sum = (pos > neg) ? pos - neg : 64'd0;
    sum = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
    if (sum > 64'd32767) begin
      sum = 64'd32767;
    end
    return sum[SINE_W-1:0];
  endfunction

  function automatic quarter_tab_t build_quarter_tab();
    quarter_tab_t t;
    for (int q = 0; q < QUARTER; q++) begin
      t[q] = quarter_sine(q);
    end
    return t;
  endfunction

  localparam quarter_tab_t QUARTER_TAB = build_quarter_tab();
  localparam logic [SINE_W-1:0] SINE_PEAK = 15'd32767;

  // full-cycle lookup: returns {negative, magnitude}
  function automatic logic [SINE_W:0] sine_lookup(input logic [SINE_TABLE_BITS-1:0] idx);
    logic [1:0]              quad;
    logic [QUARTER_BITS-1:0] q;
    logic [SINE_W-1:0]       mag;
    quad = idx[SINE_TABLE_BITS-1 -: 2];
    q    = idx[QUARTER_BITS-1:0];
    if (quad[0]) begin
      // falling quarter: mirror, the top of the wave sits at q of zero
      if (q == '0) begin
        mag = SINE_PEAK;
      end else begin
        mag = QUARTER_TAB[QUARTER_BITS'(~q + 1'b1)];
      end
    end else begin
      mag = QUARTER_TAB[q];
    end
    return {quad[1], mag};
  endfunction

endpackage

>>> hw/rtl/mpsg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsg_ctrl
// sequencer: split the lag, accumulate, walk the waves, hand off the output word
// ----------------------------------------------------------------------------
module mpsg_ctrl
  import mpsg_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_IDX  = 3'd2;
  localparam logic [2:0] S_LUT  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  logic [2:0]           state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = (cnt_q == DIV_CNT_W'(0));
        cmd_o.mul      = (cnt_q == DIV_CNT_W'(0));
        cmd_o.acc      = (cnt_q == DIV_CNT_W'(1));
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = S_IDX;
        end
      end
      S_IDX: begin
        cmd_o.idx = 1'b1;
        state_d   = S_LUT;
      end
      S_LUT: begin
        cmd_o.lut = 1'b1;
        state_d   = S_MUL;
      end
      S_MUL: begin
        cmd_o.slot = 1'b1;
        if (sts_i.wave_last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.wave_next = 1'b1;
          state_d         = S_IDX;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> hw/rtl/mpsg_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsg_datapath
// phase accumulator, lag offset split, sine lookup and amplitude scaling
// ----------------------------------------------------------------------------
module mpsg_datapath
  import mpsg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_sts_t            sts_o,
  input  logic [TICK_W-1:0]  ticks_i,
  input  logic [STEP_W-1:0]  phase_step_i,
  input  logic [AMP_W-1:0]   amplitude_i,
  input  logic [LAG_W-1:0]   lag_span_i,
  output logic [OUT_W-1:0]   result_o
);

  localparam logic [REM_W:0]    N_EXT     = (REM_W+1)'(NUM_MODULES);
  localparam logic [REM_W-1:0]  N_LOW     = REM_W'(NUM_MODULES);
  localparam logic [WAVE_W-1:0] WAVE_LAST = WAVE_W'(NUM_MODULES - 1);

  logic [TICK_W-1:0]          ticks_q;
  logic [PHASE_W-1:0]         prod_q;
  logic [PHASE_W-1:0]         acc_q;
  logic [LAG_Q_W-1:0]         lag_quo_q;
  logic [PHASE_W-1:0]         quo_q;
  logic [REM_W-1:0]           drem_q;
  logic [PHASE_W-1:0]         off_q;
  logic [REM_W-1:0]           wrem_q, wrem_d;
  logic                       wcarry;
  logic [WAVE_W-1:0]          wave_q;
  logic [SINE_TABLE_BITS-1:0] idx_q;
  logic                       neg_q;
  logic [SINE_W-1:0]          mag_q;
  logic [ANGLE_W-1:0]         slot_q [NUM_SLOTS];
  logic [OUT_W-1:0]           out_q;

  logic [STEP_W+TICK_W-1:0]     prod_full;
  logic [LAG_W+LAG_RECIP_W-1:0] lag_prod;
  logic [REM_W-1:0]             lag_rem;
  logic [PHASE_W-1:0]           wave_phase;
  logic [SINE_W:0]              sine_val;
  logic [AMP_W+SINE_W-1:0]      amp_prod;
  logic [AMP_W-1:0]             ang_mag;
  logic [ANGLE_W-1:0]           angle;
  logic [REM_W:0]               wsum;

  // lag = N*quotient + remainder; the remainder fits in the low bits
  assign lag_prod = lag_span_i * LAG_RECIP;
  assign lag_rem  = lag_span_i[REM_W-1:0] - lag_quo_q[REM_W-1:0] * N_LOW;

  // offset walk: i*lag*2^16/N built from quotient and remainder step
  assign wsum   = {1'b0, wrem_q} + {1'b0, drem_q};
  assign wcarry = (wsum >= N_EXT);
  assign wrem_d = wcarry ? REM_W'(wsum - N_EXT) : wsum[REM_W-1:0];

  assign prod_full  = phase_step_i * ticks_q;
  assign wave_phase = acc_q + off_q;
  assign sine_val   = sine_lookup(idx_q);
  assign amp_prod   = amplitude_i * mag_q;
  assign ang_mag    = amp_prod[AMP_W+SINE_W-1:SINE_W];
  assign angle      = neg_q ? (ANGLE_W'(0) - ANGLE_W'(ang_mag)) : ANGLE_W'(ang_mag);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      wave_q <= '0;
      for (int k = 0; k < NUM_SLOTS; k++) begin
        slot_q[k] <= '0;
      end
    end else begin
      if (cmd_i.acc) begin
        acc_q <= acc_q + prod_q;
      end
      if (cmd_i.load) begin
        wave_q <= '0;
      end else if (cmd_i.wave_next) begin
        wave_q <= wave_q + 1'b1;
      end
      if (cmd_i.slot) begin
        for (int k = 0; k < NUM_SLOTS; k++) begin
          if (k < NUM_MODULES && wave_q == WAVE_W'(NUM_MODULES - 1 - k)) begin
            slot_q[k] <= angle;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ticks_q   <= ticks_i;
      lag_quo_q <= LAG_Q_W'(lag_prod >> LAG_RECIP_SHIFT);
      off_q     <= '0;
      wrem_q    <= '0;
    end
    if (cmd_i.div_step) begin
      quo_q  <= {lag_quo_q, LAG_FRAC[lag_rem]};
      drem_q <= LAG_FREM[lag_rem];
    end
    if (cmd_i.mul) begin
      prod_q <= prod_full[PHASE_W-1:0];
    end
    if (cmd_i.idx) begin
      idx_q  <= wave_phase[PHASE_W-1 -: SINE_TABLE_BITS];
      off_q  <= off_q + quo_q + PHASE_W'(wcarry);
      wrem_q <= wrem_d;
    end
    if (cmd_i.lut) begin
      neg_q <= sine_val[SINE_W];
      mag_q <= sine_val[SINE_W-1:0];
    end
    if (cmd_i.out_load) begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        out_q[k*ANGLE_W +: ANGLE_W] <= slot_q[k];
      end
    end
  end

  assign sts_o.wave_last = (wave_q == WAVE_LAST);
  assign result_o        = out_q;

endmodule

>>> hw/rtl/multi_phase_sine_wave_generator.sv
`timescale 1ns / 1ps
// sequence: lag split and accumulate, then index, table read and scaling per wave
//   through the shared lookup and multiplier, then the hand-off to m_axis_tvalid
// flow: the sequencer holds one item at a time; a new word is taken once the last is handed off
// reset: async active low, clears the phase accumulator, control and slots,
//   config registers return to phase_step 4295, amplitude 0, lag span 65536
// ----------------------------------------------------------------------------
// multi_phase_sine_wave_generator
// travelling sine wave set points for a chain of motor modules
// ----------------------------------------------------------------------------
module multi_phase_sine_wave_generator
  import mpsg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input words
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,   // [15:0] elapsed_ticks
  // result words
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [39:0]        m_axis_tdata    // [7:0] angle_slot_0 .. [39:32] angle_slot_4
);

  `include "multi_phase_sine_wave_generator_assert.svh"

  logic [STEP_W-1:0]    phase_step_q;
  logic [AMP_W-1:0]     amplitude_q;
  logic [LAG_W-1:0]     lag_span_q;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // register file: word-aligned, index from paddr[3:2], unknown index ignored
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= PHASE_STEP_RST;
      amplitude_q  <= AMPLITUDE_RST;
      lag_span_q   <= LAG_SPAN_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_PHASE_STEP: phase_step_q <= pwdata;
        REG_AMPLITUDE:  amplitude_q  <= pwdata[AMP_W-1:0];
        REG_LAG_SPAN:   lag_span_q   <= pwdata[LAG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PHASE_STEP: prdata = phase_step_q;
      REG_AMPLITUDE:  prdata = 32'(amplitude_q);
      REG_LAG_SPAN:   prdata = 32'(lag_span_q);
      default:        prdata = '0;
    endcase
  end

  // sequencer
  mpsg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // accumulator, lag split, sine table and scaling; the output word
  // register lets the next item start while a result waits
  mpsg_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .ticks_i      (s_axis_tdata),
    .phase_step_i (phase_step_q),
    .amplitude_i  (amplitude_q),
    .lag_span_i   (lag_span_q),
    .result_o     (m_axis_tdata)
  );

  // a word is accepted only once before work starts
  `MPSG_ASSERT_NEXT(a_accept_then_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "double accept")
  // a pending result word is never overwritten
  `MPSG_ASSERT_SAME(a_no_overwrite, cmd.out_load, !m_axis_tvalid || m_axis_tready, "word overwritten")
  // sequencer steps that exclude each other
  `MPSG_ASSERT_ALWAYS(a_cmd_exclusive, $onehot0({cmd.load, cmd.idx, cmd.lut, cmd.slot, cmd.out_load}), "cmd clash")

endmodule
